[rtl/psdu_pkg.sv]
// ============================================================================
// Particle swarm dimension update package
// Shared widths, register codes, reset values and payload types of the
// particle swarm dimension update block.
// ============================================================================
package psdu_pkg;

    // Word format of positions, velocities and bounds (two's complement).
    localparam int WORD_BITS = 32;

    // Field and register widths.
    localparam int TAG_BITS       = 8;
    localparam int DRAW_BITS      = 16;
    localparam int GAIN_BITS      = 18;
    localparam int LIMIT_BITS     = 17;
    localparam int GAIN_FRAC      = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = GAIN_BITS;

    // A limit fraction of exactly one; larger settings act as this value.
    localparam logic [LIMIT_BITS-1:0] LIMIT_ONE = LIMIT_BITS'(1 << GAIN_FRAC);

    // Register reset values.
    localparam logic [GAIN_BITS-1:0]  INERTIA_RESET   = GAIN_BITS'(45875);
    localparam logic [GAIN_BITS-1:0]  COGNITIVE_RESET = GAIN_BITS'(98304);
    localparam logic [GAIN_BITS-1:0]  SOCIAL_RESET    = GAIN_BITS'(98304);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET     = LIMIT_BITS'(13107);

    // Saturation limits of the word.
    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_INERTIA   = 2'd0,
        CFG_COGNITIVE = 2'd1,
        CFG_SOCIAL    = 2'd2,
        CFG_LIMIT     = 2'd3
    } t_cfg_index;

    // Configuration register set.
    typedef struct packed {
        logic [GAIN_BITS-1:0]  inertia_weight;
        logic [GAIN_BITS-1:0]  cognitive_gain;
        logic [GAIN_BITS-1:0]  social_gain;
        logic [LIMIT_BITS-1:0] velocity_limit_fraction;
    } t_cfg;

    // One input request: one dimension of one particle.
    typedef struct packed {
        logic [TAG_BITS-1:0]         particle_tag;
        logic signed [WORD_BITS-1:0] position;
        logic signed [WORD_BITS-1:0] velocity;
        logic signed [WORD_BITS-1:0] personal_best;
        logic signed [WORD_BITS-1:0] global_best;
        logic signed [WORD_BITS-1:0] lower_bound;
        logic signed [WORD_BITS-1:0] upper_bound;
        logic [DRAW_BITS-1:0]        rand_personal;
        logic [DRAW_BITS-1:0]        rand_social;
        logic [DRAW_BITS-1:0]        rand_low_damp;
        logic [DRAW_BITS-1:0]        rand_high_damp;
        logic                        last_dimension;
    } t_in_item;

    // One result request.
    typedef struct packed {
        logic [TAG_BITS-1:0]         tag_out;
        logic signed [WORD_BITS-1:0] next_position;
        logic signed [WORD_BITS-1:0] next_velocity;
        logic                        end_of_particle;
    } t_out_item;

    // Hand-over from the velocity pipeline to the position pipeline.
    typedef struct packed {
        logic [TAG_BITS-1:0]         tag;
        logic                        last;
        logic signed [WORD_BITS-1:0] position;
        logic signed [WORD_BITS-1:0] lower_bound;
        logic signed [WORD_BITS-1:0] upper_bound;
        logic signed [WORD_BITS-1:0] velocity;
        logic [DRAW_BITS-1:0]        rand_low_damp;
        logic [DRAW_BITS-1:0]        rand_high_damp;
    } t_vel;

endpackage

[rtl/psdu_velocity.sv]
// ============================================================================
// Particle swarm velocity pipeline
// Four register stages: gain and difference products, attraction products
// and speed limit, velocity sum, clamp and saturation.
// ============================================================================
module psdu_velocity import psdu_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_stall,
    output t_vel     o_vel
);

    localparam int DW  = WORD_BITS + 1;
    localparam int TW  = WORD_BITS + 3;
    localparam int SW  = WORD_BITS + 5;
    localparam int GPW = DRAW_BITS + GAIN_BITS;
    localparam int P0W = WORD_BITS + GAIN_BITS + 1;
    localparam int P1W = DW + GAIN_BITS + 1;
    localparam int PVW = DW + LIMIT_BITS + 1;

    // Stage enables: a stage loads when it is empty or the next one moves.
    logic en_a, en_b, en_c, en_d;
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;

    assign en_d    = !r_d_valid || !i_stall;
    assign en_c    = !r_c_valid || en_d;
    assign en_b    = !r_b_valid || en_c;
    assign en_a    = !r_a_valid || en_b;
    assign o_stall = !en_a;
    assign o_valid = r_d_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (en_a) r_a_valid <= i_valid;
            if (en_b) r_b_valid <= r_a_valid;
            if (en_c) r_c_valid <= r_b_valid;
            if (en_d) r_d_valid <= r_c_valid;
        end
    end

    // Stage A: random gains, inertia term, differences and span.
    logic [GPW-1:0]           n_gp1, n_gp2;
    logic signed [P0W-1:0]    n_p0;
    logic [LIMIT_BITS-1:0]    n_lim;
    logic [GAIN_BITS-1:0]     r_a_g1, r_a_g2;
    logic signed [TW-1:0]     r_a_t0;
    logic signed [DW-1:0]     r_a_d1, r_a_d2, r_a_span;
    logic [LIMIT_BITS-1:0]    r_a_lim;
    t_in_item                 r_a_item;

    always_comb begin
        n_gp1 = GPW'(i_item.rand_personal) * GPW'(i_cfg.cognitive_gain);
        n_gp2 = GPW'(i_item.rand_social) * GPW'(i_cfg.social_gain);
        n_p0  = $signed({1'b0, i_cfg.inertia_weight}) * $signed(i_item.velocity);
        n_lim = (i_cfg.velocity_limit_fraction > LIMIT_ONE) ?
                LIMIT_ONE : i_cfg.velocity_limit_fraction;
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_g1   <= n_gp1[GAIN_FRAC +: GAIN_BITS];
            r_a_g2   <= n_gp2[GAIN_FRAC +: GAIN_BITS];
            r_a_t0   <= TW'(n_p0 >>> GAIN_FRAC);
            r_a_d1   <= DW'($signed(i_item.personal_best)) - DW'($signed(i_item.position));
            r_a_d2   <= DW'($signed(i_item.global_best)) - DW'($signed(i_item.position));
            r_a_span <= DW'($signed(i_item.upper_bound)) - DW'($signed(i_item.lower_bound));
            r_a_lim  <= n_lim;
            r_a_item <= i_item;
        end
    end

    // Stage B: personal and social attraction terms, speed limit.
    logic signed [P1W-1:0] n_p1, n_p2;
    logic signed [PVW-1:0] n_pv;
    logic signed [TW-1:0]  r_b_t0, r_b_t1, r_b_t2, r_b_vmax;
    t_in_item              r_b_item;

    always_comb begin
        n_p1 = $signed({1'b0, r_a_g1}) * r_a_d1;
        n_p2 = $signed({1'b0, r_a_g2}) * r_a_d2;
        n_pv = $signed({1'b0, r_a_lim}) * r_a_span;
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_t0   <= r_a_t0;
            r_b_t1   <= TW'(n_p1 >>> GAIN_FRAC);
            r_b_t2   <= TW'(n_p2 >>> GAIN_FRAC);
            r_b_vmax <= TW'(n_pv >>> GAIN_FRAC);
            r_b_item <= r_a_item;
        end
    end

    // Stage C: raw velocity sum and the negated limit.
    logic signed [SW-1:0] r_c_nv, r_c_vmax, r_c_vneg;
    t_in_item             r_c_item;

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_nv   <= SW'(r_b_t0) + SW'(r_b_t1) + SW'(r_b_t2);
            r_c_vmax <= SW'(r_b_vmax);
            r_c_vneg <= -SW'(r_b_vmax);
            r_c_item <= r_b_item;
        end
    end

    // Stage D: clamp against the upper then the lower limit, then saturate.
    // With reversed bounds the limit is negative and the result is its negation.
    logic                 n_gt, n_lt, n_rev;
    logic signed [SW-1:0] n_clamped;
    logic signed [WORD_BITS-1:0] n_vel;
    t_vel                 r_d_vel;

    always_comb begin
        n_gt  = r_c_nv > r_c_vmax;
        n_lt  = r_c_nv < r_c_vneg;
        n_rev = r_c_vmax < r_c_vneg;
        if (n_gt) begin
            n_clamped = n_rev ? r_c_vneg : r_c_vmax;
        end else begin
            n_clamped = n_lt ? r_c_vneg : r_c_nv;
        end
        if (n_clamped > SW'(WORD_MAX)) begin
            n_vel = WORD_MAX;
        end else if (n_clamped < SW'(WORD_MIN)) begin
            n_vel = WORD_MIN;
        end else begin
            n_vel = n_clamped[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_d) begin
            r_d_vel.tag            <= r_c_item.particle_tag;
            r_d_vel.last           <= r_c_item.last_dimension;
            r_d_vel.position       <= r_c_item.position;
            r_d_vel.lower_bound    <= r_c_item.lower_bound;
            r_d_vel.upper_bound    <= r_c_item.upper_bound;
            r_d_vel.velocity       <= n_vel;
            r_d_vel.rand_low_damp  <= r_c_item.rand_low_damp;
            r_d_vel.rand_high_damp <= r_c_item.rand_high_damp;
        end
    end

    assign o_vel = r_d_vel;

endmodule

[rtl/psdu_position.sv]
// ============================================================================
// Particle swarm position pipeline
// Five register stages: position step, lower fold-back product, lower
// fold-back, upper fold-back product, upper fold-back with saturation.
// ============================================================================
module psdu_position import psdu_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_vel      i_vel,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    localparam int PW = WORD_BITS + 6;
    localparam int MW = PW + DRAW_BITS + 1;

    // Stage enables, same bubble-collapsing scheme as the velocity side.
    logic en_e, en_f, en_g, en_h, en_i;
    logic r_e_valid, r_f_valid, r_g_valid, r_h_valid, r_i_valid;

    assign en_i    = !r_i_valid || !i_stall;
    assign en_h    = !r_h_valid || en_i;
    assign en_g    = !r_g_valid || en_h;
    assign en_f    = !r_f_valid || en_g;
    assign en_e    = !r_e_valid || en_f;
    assign o_stall = !en_e;
    assign o_valid = r_i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            r_i_valid <= 1'b0;
        end else begin
            if (en_e) r_e_valid <= i_valid;
            if (en_f) r_f_valid <= r_e_valid;
            if (en_g) r_g_valid <= r_f_valid;
            if (en_h) r_h_valid <= r_g_valid;
            if (en_i) r_i_valid <= r_h_valid;
        end
    end

    // Stage E: new position and its distances to both bounds.
    logic signed [PW-1:0] n_x, n_v, n_lo, n_hi;
    logic signed [PW-1:0] r_e_nx, r_e_dlo, r_e_dhi0, r_e_lmh;
    t_vel                 r_e_vel;

    always_comb begin
        n_x  = PW'($signed(i_vel.position));
        n_v  = PW'($signed(i_vel.velocity));
        n_lo = PW'($signed(i_vel.lower_bound));
        n_hi = PW'($signed(i_vel.upper_bound));
    end

    always_ff @(posedge i_clk) begin
        if (en_e) begin
            r_e_nx   <= n_x + n_v;
            r_e_dlo  <= n_x + n_v - n_lo;
            r_e_dhi0 <= n_x + n_v - n_hi;
            r_e_lmh  <= n_lo - n_hi;
            r_e_vel  <= i_vel;
        end
    end

    // Stage F: damped overshoot below the lower bound.
    logic signed [MW-1:0] n_plo;
    logic signed [PW-1:0] r_f_fl, r_f_nx, r_f_dhi0, r_f_lmh;
    logic                 r_f_below;
    t_vel                 r_f_vel;

    assign n_plo = $signed({1'b0, r_e_vel.rand_low_damp}) * r_e_dlo;

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f_fl    <= PW'(n_plo >>> GAIN_FRAC);
            r_f_below <= r_e_dlo[PW-1];
            r_f_nx    <= r_e_nx;
            r_f_dhi0  <= r_e_dhi0;
            r_f_lmh   <= r_e_lmh;
            r_f_vel   <= r_e_vel;
        end
    end

    // Stage G: fold back below the lower bound and redo the upper distance.
    logic signed [PW-1:0] r_g_nx1, r_g_dhi;
    t_vel                 r_g_vel;

    always_ff @(posedge i_clk) begin
        if (en_g) begin
            if (r_f_below) begin
                r_g_nx1 <= PW'($signed(r_f_vel.lower_bound)) - r_f_fl;
                r_g_dhi <= r_f_lmh - r_f_fl;
            end else begin
                r_g_nx1 <= r_f_nx;
                r_g_dhi <= r_f_dhi0;
            end
            r_g_vel <= r_f_vel;
        end
    end

    // Stage H: damped overshoot above the upper bound.
    logic signed [MW-1:0] n_phi;
    logic signed [PW-1:0] r_h_fh, r_h_nx1;
    logic                 r_h_above;
    t_vel                 r_h_vel;

    assign n_phi = $signed({1'b0, r_g_vel.rand_high_damp}) * r_g_dhi;

    always_ff @(posedge i_clk) begin
        if (en_h) begin
            r_h_fh    <= PW'(n_phi >>> GAIN_FRAC);
            r_h_above <= !r_g_dhi[PW-1] && (r_g_dhi != '0);
            r_h_nx1   <= r_g_nx1;
            r_h_vel   <= r_g_vel;
        end
    end

    // Stage I: fold back above the upper bound, saturate, output register.
    logic signed [PW-1:0]        n_nx2;
    logic signed [WORD_BITS-1:0] n_pos;
    t_out_item                   r_i_item;

    always_comb begin
        n_nx2 = r_h_above ? (PW'($signed(r_h_vel.upper_bound)) - r_h_fh) : r_h_nx1;
        if (n_nx2 > PW'(WORD_MAX)) begin
            n_pos = WORD_MAX;
        end else if (n_nx2 < PW'(WORD_MIN)) begin
            n_pos = WORD_MIN;
        end else begin
            n_pos = n_nx2[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_i) begin
            r_i_item.tag_out         <= r_h_vel.tag;
            r_i_item.next_position   <= n_pos;
            r_i_item.next_velocity   <= r_h_vel.velocity;
            r_i_item.end_of_particle <= r_h_vel.last;
        end
    end

    assign o_item = r_i_item;

endmodule

[rtl/swarm_particle_dimension_update.sv]
// ============================================================================
// Particle swarm dimension update
// Takes one dimension of one particle per request and returns its new
// velocity and its boundary-damped position.
//
// The block accepts one request every clock cycle whenever o_in_stall is low,
// and returns one result for each, in order. That rate comes from a
// nine-stage register pipeline (four velocity stages, five position stages)
// whose stages each hold one request; empty stages close up while the output
// is stalled, so the input keeps taking requests until every stage is full.
// The configuration port is always ready, and its registers are meant to be
// written only while no request is in flight. Values are signed Q16.16 in a
// 32-bit word, gains unsigned Q2.16, the speed limit fraction unsigned Q1.16.
// ============================================================================
module swarm_particle_dimension_update import psdu_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_in_item                  i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_out_item                 o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    t_cfg r_cfg;
    logic vel_valid;
    logic pos_stall;
    t_vel vel_data;

    // Configuration registers, one write per request.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inertia_weight          <= INERTIA_RESET;
            r_cfg.cognitive_gain          <= COGNITIVE_RESET;
            r_cfg.social_gain             <= SOCIAL_RESET;
            r_cfg.velocity_limit_fraction <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INERTIA: begin
                    r_cfg.inertia_weight <= i_cfg_data;
                end
                CFG_COGNITIVE: begin
                    r_cfg.cognitive_gain <= i_cfg_data;
                end
                CFG_SOCIAL: begin
                    r_cfg.social_gain <= i_cfg_data;
                end
                CFG_LIMIT: begin
                    r_cfg.velocity_limit_fraction <= i_cfg_data[LIMIT_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Velocity pipeline.
    psdu_velocity u_velocity (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_data),
        .o_valid (vel_valid),
        .i_stall (pos_stall),
        .o_vel   (vel_data)
    );

    // Position pipeline with the output register.
    psdu_position u_position (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (vel_valid),
        .o_stall (pos_stall),
        .i_vel   (vel_data),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_data)
    );

`ifndef SYNTHESIS
    // The input may only stall when every stage is full and the output is held.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline still had room");

    // Reset empties the pipeline and releases the input.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");

    // A write to the inertia register lands in the next cycle.
    a_inertia_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready && i_cfg_index == CFG_INERTIA)
        |=> (r_cfg.inertia_weight == $past(i_cfg_data)))
        else $error("inertia register write lost");
`endif

endmodule
